>>> hdl/imgconv_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// imgconv_pkg: shared types and constants of the 2D image convolution unit.
// Holds the item payload structs, configuration register layout and codes.
// -----------------------------------------------------------------------------
package imgconv_pkg;

  // Default sizes of the datapath.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_KSIZE  = 7;
  localparam int COEF_FRAC  = 16;
  localparam int COEF_WIDTH = 24;

  // Field widths of the items.
  localparam int PIX_W  = 32;
  localparam int CIDX_W = 6;
  localparam int CVAL_W = 24;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;

  // Configuration register widths and reset values.
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 13;
  localparam int KS_W    = 3;
  localparam int MODE_W  = 2;
  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 13'd1024;
  localparam logic [KS_W-1:0]    KS_RST    = 3'd3;
  localparam logic [MODE_W-1:0]  MODE_RST  = 2'd0;

  // APB register map.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_MODE   = 3'd4;

  // Item operation codes.
  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Pixel depth codes.
  localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 2'd1;

  typedef struct packed {
    logic                     op;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [CVAL_W-1:0] coef_value;
    logic [PIX_W-1:0]         pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
    logic [KS_W-1:0]    kernel_cols;
    logic [KS_W-1:0]    kernel_rows;
    logic [MODE_W-1:0]  pixel_mode;
  } cfg_t;

  // Coefficient write travelling to the coefficient table.
  typedef struct packed {
    logic                     we;
    logic [CIDX_W-1:0]        idx;
    logic signed [CVAL_W-1:0] value;
  } coef_wr_t;

  // Result tag that travels alongside the arithmetic pipeline.
  typedef struct packed {
    logic             res;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } side_t;

  // Largest value of the selected pixel depth.
  function automatic logic [PIX_W-1:0] mode_max(input logic [MODE_W-1:0] mode);
    logic [PIX_W-1:0] m;
    case (mode)
      MODE_8:  m = 32'h0000_00ff;
      MODE_16: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> hdl/image_convolution_2d_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// image_convolution_2d_unit: streaming 2D convolution, odd kernel up to 7x7.
// Coefficient items load the tap table; pixel items in raster order give one
// floored, clamped result per interior pixel.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_item_i  (in_item_t)
//   out      output     out_valid_o / out_ready_i out_item_o (out_item_t)
//   config   input      APB psel/penable/pready   paddr, pwdata, prdata
//
// One item is taken per cycle while no result is held at the output; a result
// passes the line store read, window shift, tap register, multiply, six adder
// tree levels and the clamp into the output register.
// Column words live in one line store memory, read and written back per pixel.
// A held output result stalls the whole pipeline; nothing is dropped.
// Reset clears the window, coefficient table and counters; no clearing pass.
// -----------------------------------------------------------------------------
module image_convolution_2d_unit #(
  parameter int MAX_WIDTH  = imgconv_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = imgconv_pkg::MAX_HEIGHT,
  parameter int MAX_KSIZE  = imgconv_pkg::MAX_KSIZE,
  parameter int COEF_FRAC  = imgconv_pkg::COEF_FRAC,
  parameter int COEF_WIDTH = imgconv_pkg::COEF_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire imgconv_pkg::in_item_t              in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output imgconv_pkg::out_item_t                  out_item_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [imgconv_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [imgconv_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [imgconv_pkg::APB_DATA_W-1:0] prdata,
  output logic                                    pready
);

  localparam int TAPS    = MAX_KSIZE * MAX_KSIZE;
  localparam int LS_ROWS = MAX_KSIZE - 1;
  localparam int K_ODD   = (MAX_KSIZE % 2 == 1) ? MAX_KSIZE : MAX_KSIZE - 1;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int SW      = $clog2(LS_ROWS);
  localparam int KW      = $clog2(MAX_KSIZE + 1);
  localparam int LV      = $clog2(TAPS);
  localparam int DEPTH   = 4 + LV;
  localparam int KS_W_L  = imgconv_pkg::KS_W;

  imgconv_pkg::cfg_t     cfg;
  logic                  adv;
  logic                  accept;
  logic                  is_pix;
  logic [CW:0]           w_eff;
  logic [RW:0]           h_eff;
  logic [KS_W_L-1:0]     kc_raw;
  logic [KS_W_L-1:0]     kr_raw;
  logic [KW-1:0]         kc;
  logic [KW-1:0]         kr;
  logic [imgconv_pkg::PIX_W-1:0] maxv;
  logic [imgconv_pkg::PIX_W-1:0] pix_m;
  logic                  col_last;
  logic                  row_last;
  imgconv_pkg::side_t    side_new;

  // Pixel position counters.
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [SW-1:0] slot_q;

  // Item registers in front of the window update.
  logic                          s1_valid_q;
  logic                          s1_op_q;
  logic [imgconv_pkg::PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]                 s1_col_q;
  logic [SW-1:0]                 s1_slot_q;
  logic [imgconv_pkg::CIDX_W-1:0]        s1_cidx_q;
  logic signed [imgconv_pkg::CVAL_W-1:0] s1_cval_q;

  imgconv_pkg::side_t     side_q [DEPTH];
  logic                   out_valid_q;
  imgconv_pkg::out_item_t out_item_q;

  logic [LS_ROWS-1:0][imgconv_pkg::PIX_W-1:0] lanes;
  imgconv_pkg::coef_wr_t  coef_wr;
  logic signed [COEF_WIDTH-1:0]  tap_coef [TAPS];
  logic [imgconv_pkg::PIX_W-1:0] tap_pix  [TAPS];
  logic [imgconv_pkg::PIX_W-1:0] mac_result;

  imgconv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  // Effective frame size, kernel size and pixel depth.
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(cfg.image_height);
    end
    kc_raw = cfg.kernel_cols | KS_W_L'(1);
    kr_raw = cfg.kernel_rows | KS_W_L'(1);
    kc = (32'(kc_raw) > K_ODD) ? KW'(K_ODD) : KW'(kc_raw);
    kr = (32'(kr_raw) > K_ODD) ? KW'(K_ODD) : KW'(kr_raw);
    maxv = imgconv_pkg::mode_max(cfg.pixel_mode);
  end

  // The pipeline moves whenever the output register can take a result.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign is_pix     = (in_item_i.op == imgconv_pkg::OP_PIXEL);
  assign pix_m      = in_item_i.pixel & maxv;

  assign col_last = ({1'b0, col_q} + (CW+1)'(1)) >= w_eff;
  assign row_last = ({1'b0, row_q} + (RW+1)'(1)) >= h_eff;

  // Result tag of the accepted pixel.
  always_comb begin
    side_new.res  = accept && is_pix &&
                    (({1'b0, col_q} + (CW+1)'(1)) >= (CW+1)'(kc)) &&
                    (({1'b0, row_q} + (RW+1)'(1)) >= (RW+1)'(kr));
    side_new.col  = imgconv_pkg::COL_W'(col_q - CW'(kc >> 1));
    side_new.row  = imgconv_pkg::ROW_W'(row_q - RW'(kr >> 1));
    side_new.last = col_last && row_last;
  end

  // Column, row and line slot counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept && is_pix) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + RW'(1);
          slot_q <= (slot_q == SW'(LS_ROWS - 1)) ? '0 : slot_q + SW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Item stage beside the line store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= in_item_i.op;
      s1_pix_q  <= pix_m;
      s1_col_q  <= col_q;
      s1_slot_q <= slot_q;
      s1_cidx_q <= in_item_i.coef_index;
      s1_cval_q <= in_item_i.coef_value;
    end
  end

  imgconv_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_KSIZE (MAX_KSIZE)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && is_pix),
    .rd_addr_i (col_q),
    .wr_en_i   (adv && s1_valid_q && (s1_op_q == imgconv_pkg::OP_PIXEL)),
    .wr_addr_i (s1_col_q),
    .wr_slot_i (s1_slot_q),
    .wr_pix_i  (s1_pix_q),
    .lanes_o   (lanes)
  );

  always_comb begin
    coef_wr.we    = s1_valid_q && (s1_op_q == imgconv_pkg::OP_COEF);
    coef_wr.idx   = s1_cidx_q;
    coef_wr.value = s1_cval_q;
  end

  imgconv_window #(
    .MAX_KSIZE  (MAX_KSIZE),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .shift_i    (s1_valid_q && (s1_op_q == imgconv_pkg::OP_PIXEL)),
    .pix_i      (s1_pix_q),
    .slot_i     (s1_slot_q),
    .lanes_i    (lanes),
    .kc_i       (kc),
    .kr_i       (kr),
    .coef_wr_i  (coef_wr),
    .tap_coef_o (tap_coef),
    .tap_pix_o  (tap_pix)
  );

  imgconv_mac #(
    .MAX_KSIZE  (MAX_KSIZE),
    .COEF_WIDTH (COEF_WIDTH),
    .COEF_FRAC  (COEF_FRAC)
  ) u_mac (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .tap_coef_i (tap_coef),
    .tap_pix_i  (tap_pix),
    .maxv_i     (maxv),
    .result_o   (mac_result)
  );

  // Result tags follow the arithmetic pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        side_q[k] <= '0;
      end
    end else if (adv) begin
      side_q[0] <= side_new;
      for (int k = 1; k < DEPTH; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= side_q[DEPTH-1].res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q.out_pixel  <= mac_result;
      out_item_q.out_col    <= side_q[DEPTH-1].col;
      out_item_q.out_row    <= side_q[DEPTH-1].row;
      out_item_q.frame_last <= side_q[DEPTH-1].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  // The line slot always names a stored row.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SW'(LS_ROWS - 1) || slot_q == SW'(LS_ROWS - 1))
    else $error("line slot out of range");

  // The last pixel of a frame restarts row and slot at zero.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pix && col_last && row_last) |=> (row_q == '0 && slot_q == '0))
    else $error("frame wrap did not clear row counters");

  // The input side only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");
`endif

endmodule
`default_nettype wire

>>> hdl/imgconv_regs.sv
`default_nettype none
// -----------------------------------------------------------------------------
// imgconv_regs: APB configuration registers.
// Holds frame size, kernel size and pixel depth; reads return the stored value.
// -----------------------------------------------------------------------------
module imgconv_regs (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [imgconv_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [imgconv_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [imgconv_pkg::APB_DATA_W-1:0]    prdata,
  output imgconv_pkg::cfg_t                          cfg_o
);

  imgconv_pkg::cfg_t cfg_q;
  logic [imgconv_pkg::REG_IDX_W-1:0] idx;

  assign idx = paddr[imgconv_pkg::APB_ADDR_W-1:2];

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= imgconv_pkg::IMG_W_RST;
      cfg_q.image_height <= imgconv_pkg::IMG_H_RST;
      cfg_q.kernel_cols  <= imgconv_pkg::KS_RST;
      cfg_q.kernel_rows  <= imgconv_pkg::KS_RST;
      cfg_q.pixel_mode   <= imgconv_pkg::MODE_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        imgconv_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[imgconv_pkg::IMG_W_W-1:0];
        imgconv_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[imgconv_pkg::IMG_H_W-1:0];
        imgconv_pkg::REG_KERNEL_COLS:  cfg_q.kernel_cols  <= pwdata[imgconv_pkg::KS_W-1:0];
        imgconv_pkg::REG_KERNEL_ROWS:  cfg_q.kernel_rows  <= pwdata[imgconv_pkg::KS_W-1:0];
        imgconv_pkg::REG_PIXEL_MODE:   cfg_q.pixel_mode   <= pwdata[imgconv_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (idx)
      imgconv_pkg::REG_IMAGE_WIDTH:  prdata = imgconv_pkg::APB_DATA_W'(cfg_q.image_width);
      imgconv_pkg::REG_IMAGE_HEIGHT: prdata = imgconv_pkg::APB_DATA_W'(cfg_q.image_height);
      imgconv_pkg::REG_KERNEL_COLS:  prdata = imgconv_pkg::APB_DATA_W'(cfg_q.kernel_cols);
      imgconv_pkg::REG_KERNEL_ROWS:  prdata = imgconv_pkg::APB_DATA_W'(cfg_q.kernel_rows);
      imgconv_pkg::REG_PIXEL_MODE:   prdata = imgconv_pkg::APB_DATA_W'(cfg_q.pixel_mode);
      default:                       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> hdl/imgconv_line_store.sv
`default_nettype none
// -----------------------------------------------------------------------------
// imgconv_line_store: line buffer memory, one word per column.
// Each word holds one pixel for every row slot; a pixel is read, merged into
// its slot and written back, with forwarding when a column is reused at once.
// -----------------------------------------------------------------------------
module imgconv_line_store #(
  parameter int MAX_WIDTH = imgconv_pkg::MAX_WIDTH,
  parameter int MAX_KSIZE = imgconv_pkg::MAX_KSIZE
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    rd_en_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]            rd_addr_i,
  input  wire logic                                    wr_en_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]            wr_addr_i,
  input  wire logic [$clog2(MAX_KSIZE-1)-1:0]          wr_slot_i,
  input  wire logic [imgconv_pkg::PIX_W-1:0]           wr_pix_i,
  output logic [MAX_KSIZE-2:0][imgconv_pkg::PIX_W-1:0] lanes_o
);

  localparam int LS_ROWS = MAX_KSIZE - 1;

  typedef logic [LS_ROWS-1:0][imgconv_pkg::PIX_W-1:0] word_t;

  word_t mem [MAX_WIDTH];
  word_t rdata_q;
  word_t last_q;
  word_t wr_word;
  logic  fwd_q;

  // Memory port: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Keep the last written word for a read that raced its write.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      last_q <= wr_word;
    end
  end

  // Flag a read that hit the column being written in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  // Current column word and its merge with the new pixel.
  always_comb begin
    lanes_o = fwd_q ? last_q : rdata_q;
    wr_word = lanes_o;
    wr_word[wr_slot_i] = wr_pix_i;
  end

endmodule
`default_nettype wire

>>> hdl/imgconv_window.sv
`default_nettype none
// -----------------------------------------------------------------------------
// imgconv_window: kernel window registers and coefficient table.
// Shifts a new column into the window and registers the coefficient and pixel
// of every tap for the multiply stage.
// -----------------------------------------------------------------------------
module imgconv_window #(
  parameter int MAX_KSIZE  = imgconv_pkg::MAX_KSIZE,
  parameter int COEF_WIDTH = imgconv_pkg::COEF_WIDTH
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    adv_i,
  input  wire logic                                    shift_i,
  input  wire logic [imgconv_pkg::PIX_W-1:0]           pix_i,
  input  wire logic [$clog2(MAX_KSIZE-1)-1:0]          slot_i,
  input  wire logic [MAX_KSIZE-2:0][imgconv_pkg::PIX_W-1:0] lanes_i,
  input  wire logic [$clog2(MAX_KSIZE+1)-1:0]          kc_i,
  input  wire logic [$clog2(MAX_KSIZE+1)-1:0]          kr_i,
  input  wire imgconv_pkg::coef_wr_t                   coef_wr_i,
  output logic signed [COEF_WIDTH-1:0]                 tap_coef_o [MAX_KSIZE*MAX_KSIZE],
  output logic [imgconv_pkg::PIX_W-1:0]                tap_pix_o  [MAX_KSIZE*MAX_KSIZE]
);

  localparam int TAPS    = MAX_KSIZE * MAX_KSIZE;
  localparam int LS_ROWS = MAX_KSIZE - 1;
  localparam int SW      = $clog2(LS_ROWS);
  localparam int TW      = $clog2(5 * LS_ROWS);
  localparam int TI      = $clog2(TAPS);
  localparam int K_ODD   = (MAX_KSIZE % 2 == 1) ? MAX_KSIZE : MAX_KSIZE - 1;

  logic [imgconv_pkg::PIX_W-1:0] win_q [MAX_KSIZE][MAX_KSIZE];
  logic signed [COEF_WIDTH-1:0]  coef_q [TAPS];
  logic [imgconv_pkg::PIX_W-1:0] newc [MAX_KSIZE];
  logic [TW-1:0]                 slot_t [MAX_KSIZE];
  logic signed [COEF_WIDTH-1:0]  csel [TAPS];

  // Column entering the window: line store rows above, new pixel at the bottom.
  always_comb begin
    for (int i = 0; i < MAX_KSIZE; i++) begin
      slot_t[i] = TW'(slot_i) + TW'(2 * LS_ROWS + 1 + i) - TW'(kr_i);
      for (int s = 0; s < 4; s++) begin
        if (slot_t[i] >= TW'(LS_ROWS)) begin
          slot_t[i] = slot_t[i] - TW'(LS_ROWS);
        end
      end
      if ((i + 1) == int'(kr_i)) begin
        newc[i] = pix_i;
      end else if (i < LS_ROWS) begin
        newc[i] = lanes_i[SW'(slot_t[i])];
      end else begin
        newc[i] = '0;
      end
    end
  end

  // Window shift for the active kernel rows and columns.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_KSIZE; i++) begin
        for (int j = 0; j < MAX_KSIZE; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (adv_i && shift_i) begin
      for (int i = 0; i < MAX_KSIZE; i++) begin
        for (int j = 0; j < MAX_KSIZE; j++) begin
          if (i < int'(kr_i)) begin
            if ((j + 1) < int'(kc_i)) begin
              win_q[i][j] <= win_q[i][j+1];
            end else if ((j + 1) == int'(kc_i)) begin
              win_q[i][j] <= newc[i];
            end
          end
        end
      end
    end
  end

  // Coefficient table, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TAPS; t++) begin
        coef_q[t] <= '0;
      end
    end else if (adv_i && coef_wr_i.we && (int'(coef_wr_i.idx) < TAPS)) begin
      coef_q[TI'(coef_wr_i.idx)] <= COEF_WIDTH'(coef_wr_i.value);
    end
  end

  // Coefficients are row-major with the current kernel width.
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      csel[t] = '0;
    end
    for (int i = 0; i < MAX_KSIZE; i++) begin
      for (int j = 0; j < MAX_KSIZE; j++) begin
        for (int v = 1; v <= K_ODD; v += 2) begin
          if ((int'(kc_i) == v) && (j < v) && (i < int'(kr_i))) begin
            csel[i*MAX_KSIZE+j] = coef_q[i*v+j];
          end
        end
      end
    end
  end

  // Tap registers feeding the multipliers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < MAX_KSIZE; i++) begin
        for (int j = 0; j < MAX_KSIZE; j++) begin
          tap_coef_o[i*MAX_KSIZE+j] <= csel[i*MAX_KSIZE+j];
          tap_pix_o[i*MAX_KSIZE+j]  <= ((i < int'(kr_i)) && (j < int'(kc_i))) ?
                                       win_q[i][j] : '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/imgconv_mac.sv
`default_nettype none
// -----------------------------------------------------------------------------
// imgconv_mac: tap multipliers, pipelined adder tree and output clamp.
// One registered product per tap, a register after each tree level, then floor and
// clamp to zero and the pixel depth maximum.
// -----------------------------------------------------------------------------
module imgconv_mac #(
  parameter int MAX_KSIZE  = imgconv_pkg::MAX_KSIZE,
  parameter int COEF_WIDTH = imgconv_pkg::COEF_WIDTH,
  parameter int COEF_FRAC  = imgconv_pkg::COEF_FRAC
) (
  input  wire logic                          clk_i,
  input  wire logic                          adv_i,
  input  wire logic signed [COEF_WIDTH-1:0]  tap_coef_i [MAX_KSIZE*MAX_KSIZE],
  input  wire logic [imgconv_pkg::PIX_W-1:0] tap_pix_i  [MAX_KSIZE*MAX_KSIZE],
  input  wire logic [imgconv_pkg::PIX_W-1:0] maxv_i,
  output logic [imgconv_pkg::PIX_W-1:0]      result_o
);

  localparam int TAPS   = MAX_KSIZE * MAX_KSIZE;
  localparam int LV     = $clog2(TAPS);
  localparam int NLEAF  = 1 << LV;
  localparam int PROD_W = COEF_WIDTH + imgconv_pkg::PIX_W + 1;
  localparam int SUM_W  = PROD_W + LV;

  logic signed [SUM_W-1:0]  node_q [2*NLEAF-1];
  logic signed [PROD_W-1:0] prod [TAPS];
  logic [SUM_W-1:0]         quot;

  // Signed coefficient times unsigned pixel, exact.
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      prod[t] = PROD_W'(tap_coef_i[t]) * PROD_W'($signed({1'b0, tap_pix_i[t]}));
    end
  end

  // Leaves are the products; each inner node adds its two children.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int t = 0; t < TAPS; t++) begin
        node_q[NLEAF-1+t] <= SUM_W'(prod[t]);
      end
      for (int t = TAPS; t < NLEAF; t++) begin
        node_q[NLEAF-1+t] <= '0;
      end
      for (int n = 0; n < NLEAF - 1; n++) begin
        node_q[n] <= node_q[2*n+1] + node_q[2*n+2];
      end
    end
  end

  // Floor to whole units, then clamp.
  always_comb begin
    quot = node_q[0] >>> COEF_FRAC;
    if (node_q[0][SUM_W-1]) begin
      result_o = '0;
    end else if (quot > SUM_W'(maxv_i)) begin
      result_o = maxv_i;
    end else begin
      result_o = quot[imgconv_pkg::PIX_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tb_top: self-checking testbench of the 2D image convolution unit.
// A queue-fed driver sends coefficient and pixel items while a monitor checks
// each result against a behavioral convolution model kept in this file. The
// line store is filled once over every column that later phases reach, then
// directed and random phases sweep frame sizes, kernel sizes and pixel depths
// under random idling.
// -----------------------------------------------------------------------------
module tb_top;

  localparam int LS_ROWS   = imgconv_pkg::MAX_KSIZE - 1;
  localparam int TAPS      = imgconv_pkg::MAX_KSIZE * imgconv_pkg::MAX_KSIZE;
  localparam int MEM_W     = imgconv_pkg::MAX_WIDTH;
  localparam int FILL_W    = 48;
  localparam int PHASE_N   = 40;
  localparam int WDOG_MAX  = 5000;
  localparam int DRAIN_CYC = 16;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  imgconv_pkg::in_item_t  in_item_i;
  imgconv_pkg::out_item_t out_item_o;
  logic psel, penable, pwrite, pready;
  logic [imgconv_pkg::APB_ADDR_W-1:0] paddr;
  logic [imgconv_pkg::APB_DATA_W-1:0] pwdata, prdata;

  // Stimulus, expected results and run status.
  imgconv_pkg::in_item_t  pixel_stream_q[$];
  imgconv_pkg::out_item_t conv_expect_q[$];
  int        err_cnt;
  int        src_idle, dst_idle;
  int        stall_cnt;

  // Shadow of the configuration registers.
  logic [imgconv_pkg::IMG_W_W-1:0] sh_width;
  logic [imgconv_pkg::IMG_H_W-1:0] sh_height;
  logic [imgconv_pkg::KS_W-1:0]    sh_kcols, sh_krows;
  logic [imgconv_pkg::MODE_W-1:0]  sh_mode;

  // Shadow of the datapath state.
  logic [imgconv_pkg::PIX_W-1:0]         line_mem[LS_ROWS*MEM_W];
  logic [imgconv_pkg::PIX_W-1:0]         win[TAPS];
  logic signed [imgconv_pkg::CVAL_W-1:0] taps[TAPS];
  int unsigned                           col_cnt, row_cnt;

  image_convolution_2d_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Applies one item to the shadow state; returns 1 when a result is due.
  function automatic logic convolve_pixel(input imgconv_pkg::in_item_t it,
                                          output imgconv_pkg::out_item_t res);
    int unsigned w, h, kc, kr, c, r, slot;
    logic [imgconv_pkg::PIX_W-1:0] maxv, pix, nv;
    logic signed [71:0] acc, a, b, q;
    res = '0;
    if (it.op == imgconv_pkg::OP_COEF) begin
      if (it.coef_index < TAPS) taps[it.coef_index] = it.coef_value;
      return 1'b0;
    end
    w  = (sh_width == 0) ? 1 :
         ((sh_width > imgconv_pkg::MAX_WIDTH) ? imgconv_pkg::MAX_WIDTH : sh_width);
    h  = (sh_height == 0) ? 1 :
         ((sh_height > imgconv_pkg::MAX_HEIGHT) ? imgconv_pkg::MAX_HEIGHT : sh_height);
    kc = sh_kcols | 1;
    kr = sh_krows | 1;
    if (kc > imgconv_pkg::MAX_KSIZE) kc = imgconv_pkg::MAX_KSIZE;
    if (kr > imgconv_pkg::MAX_KSIZE) kr = imgconv_pkg::MAX_KSIZE;
    case (sh_mode)
      imgconv_pkg::MODE_8:  maxv = 32'h0000_00ff;
      imgconv_pkg::MODE_16: maxv = 32'h0000_ffff;
      default:              maxv = 32'hffff_ffff;
    endcase
    c   = col_cnt;
    r   = row_cnt;
    pix = it.pixel & maxv;
    // Shift the window left and load the new column from the line store.
    for (int i = 0; i < kr; i++) begin
      for (int j = 0; j + 1 < kc; j++)
        win[i*imgconv_pkg::MAX_KSIZE+j] = win[i*imgconv_pkg::MAX_KSIZE+j+1];
      if (i + 1 == kr) begin
        nv = pix;
      end else begin
        slot = ((r % LS_ROWS) + 2*LS_ROWS - (kr - 1) + i) % LS_ROWS;
        nv   = line_mem[slot*MEM_W+c];
      end
      win[i*imgconv_pkg::MAX_KSIZE+kc-1] = nv;
    end
    line_mem[(r % LS_ROWS)*MEM_W+c] = pix;
    convolve_pixel = 1'b0;
    // Interior pixel: exact product sum, floor, then clamp.
    if (c + 1 >= kc && r + 1 >= kr) begin
      acc = '0;
      for (int i = 0; i < kr; i++) begin
        for (int j = 0; j < kc; j++) begin
          a   = taps[i*kc+j];
          b   = {40'd0, win[i*imgconv_pkg::MAX_KSIZE+j]};
          acc = acc + a * b;
        end
      end
      q = acc >>> imgconv_pkg::COEF_FRAC;
      if (q < 0) res.out_pixel = '0;
      else if (q > $signed({40'd0, maxv})) res.out_pixel = maxv;
      else res.out_pixel = q[31:0];
      res.out_col    = imgconv_pkg::COL_W'(c - kc/2);
      res.out_row    = imgconv_pkg::ROW_W'(r - kr/2);
      res.frame_last = (c + 1 >= w && r + 1 >= h);
      convolve_pixel = 1'b1;
    end
    // Advance the raster position.
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Driver: predicts each accepted item and presents the next pending one.
  always @(posedge clk_i or negedge rst_ni) begin
    imgconv_pkg::out_item_t r_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (convolve_pixel(in_item_i, r_item)) conv_expect_q.push_back(r_item);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_stream_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          in_item_i  <= pixel_stream_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    imgconv_pkg::out_item_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (conv_expect_q.size() == 0) begin
          report_mismatch("result with no expectation");
        end else begin
          e = conv_expect_q.pop_front();
          if (out_item_o.out_pixel !== e.out_pixel)
            report_mismatch($sformatf("out_pixel %h, expected %h",
                                      out_item_o.out_pixel, e.out_pixel));
          if (out_item_o.out_col !== e.out_col)
            report_mismatch($sformatf("out_col %0d, expected %0d",
                                      out_item_o.out_col, e.out_col));
          if (out_item_o.out_row !== e.out_row)
            report_mismatch($sformatf("out_row %0d, expected %0d",
                                      out_item_o.out_row, e.out_row));
          if (out_item_o.frame_last !== e.frame_last)
            report_mismatch($sformatf("frame_last %b, expected %b",
                                      out_item_o.frame_last, e.frame_last));
        end
      end
      out_ready_i <= ($urandom_range(99) >= dst_idle);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("** image_convolution_2d_unit: FAILED **");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Writes one configuration register and updates the shadow copy.
  task automatic reg_write(input logic [imgconv_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= imgconv_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      imgconv_pkg::REG_IMAGE_WIDTH:  sh_width  = val[imgconv_pkg::IMG_W_W-1:0];
      imgconv_pkg::REG_IMAGE_HEIGHT: sh_height = val[imgconv_pkg::IMG_H_W-1:0];
      imgconv_pkg::REG_KERNEL_COLS:  sh_kcols  = val[imgconv_pkg::KS_W-1:0];
      imgconv_pkg::REG_KERNEL_ROWS:  sh_krows  = val[imgconv_pkg::KS_W-1:0];
      default:                       sh_mode   = val[imgconv_pkg::MODE_W-1:0];
    endcase
  endtask

  task automatic set_config(input int w, input int h, input int kc, input int kr,
                            input int m);
    reg_write(imgconv_pkg::REG_IMAGE_WIDTH, w);
    reg_write(imgconv_pkg::REG_IMAGE_HEIGHT, h);
    reg_write(imgconv_pkg::REG_KERNEL_COLS, kc);
    reg_write(imgconv_pkg::REG_KERNEL_ROWS, kr);
    reg_write(imgconv_pkg::REG_PIXEL_MODE, m);
  endtask

  // Waits until all items are sent and all results are in, then lets the
  // pipeline settle.
  task automatic wait_drained();
    while (pixel_stream_q.size() > 0 || in_valid_i || conv_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic push_item(input logic op, input int idx, input logic [31:0] cv,
                           input logic [31:0] px);
    imgconv_pkg::in_item_t it;
    it            = '0;
    it.op         = op;
    it.coef_index = imgconv_pkg::CIDX_W'(idx);
    it.coef_value = cv[imgconv_pkg::CVAL_W-1:0];
    it.pixel      = px;
    pixel_stream_q.push_back(it);
  endtask

  // Random items: mostly pixels, some coefficient writes.
  task automatic push_random(input int n);
    imgconv_pkg::in_item_t it;
    int sel;
    for (int k = 0; k < n; k++) begin
      it  = $bits(imgconv_pkg::in_item_t)'({$urandom, $urandom});
      sel = $urandom_range(99);
      if (sel < 15) begin
        it.op = imgconv_pkg::OP_COEF;
        it.coef_index = ($urandom_range(99) < 90) ?
                        imgconv_pkg::CIDX_W'($urandom_range(0, 48)) :
                        imgconv_pkg::CIDX_W'($urandom_range(49, 63));
        if ($urandom_range(1))
          it.coef_value = imgconv_pkg::CVAL_W'($urandom_range(0, 40000)) - 24'sd12000;
      end else begin
        it.op = imgconv_pkg::OP_PIXEL;
        if (sel < 20) it.pixel = '0;
        else if (sel < 25) it.pixel = '1;
      end
      pixel_stream_q.push_back(it);
    end
  endtask

  function automatic int pick_size(input int hi_lo, input int hi_hi, input int norm);
    int s;
    s = $urandom_range(99);
    if (s < 5) return 0;
    if (s < 8) return $urandom_range(hi_lo, hi_hi);
    return $urandom_range(1, norm);
  endfunction

  // Main sequence.
  initial begin
    rst_ni    = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    err_cnt   = 0;
    stall_cnt = 0;
    src_idle  = 19;
    dst_idle  = 46;
    sh_width  = imgconv_pkg::IMG_W_RST;
    sh_height = imgconv_pkg::IMG_H_RST;
    sh_kcols  = imgconv_pkg::KS_RST;
    sh_krows  = imgconv_pkg::KS_RST;
    sh_mode   = imgconv_pkg::MODE_RST;
    col_cnt   = 0;
    row_cnt   = 0;
    foreach (win[i]) win[i] = '0;
    foreach (taps[i]) taps[i] = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every line slot over the columns that later phases can reach,
    // using a 1x1 kernel. Wider frames below never run past these columns.
    set_config(FILL_W, LS_ROWS, 1, 1, imgconv_pkg::MODE_8);
    push_item(imgconv_pkg::OP_COEF, 0, 32'h0001_0000, 0);
    for (int k = 0; k < LS_ROWS*FILL_W; k++)
      push_item(imgconv_pkg::OP_PIXEL, 0, 0, $urandom);
    wait_drained();

    // Directed: coefficient extremes, ignored index, pixel extremes, 32 bit.
    set_config(5, 4, 3, 3, 2);
    push_item(imgconv_pkg::OP_COEF, 0, 32'h007f_ffff, 0);
    push_item(imgconv_pkg::OP_COEF, 1, 32'h0080_0000, 0);
    push_item(imgconv_pkg::OP_COEF, 63, 32'h00ff_ffff, 32'hffff_ffff);
    push_item(imgconv_pkg::OP_COEF, 48, 32'h0000_0001, 0);
    push_item(imgconv_pkg::OP_COEF, 4, 32'h0001_0000, 0);
    for (int k = 0; k < 20; k++)
      push_item(imgconv_pkg::OP_PIXEL, 0, 0,
                (k % 3 == 0) ? 32'h0 : (k % 3 == 1) ? 32'hffff_ffff : $urandom);
    wait_drained();

    // Random phases across sizes, kernels and depths.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        src_idle = 19; dst_idle = 46;
      end else if (ph < 8) begin
        src_idle = 46; dst_idle = 19;
      end else begin
        src_idle = 0; dst_idle = 0;
      end
      if (ph == 0) set_config(1, 1, 7, 7, 1);
      else if (ph == 1) set_config(2047, 8191, 0, 6, 3);
      else set_config(pick_size(13, 16, 12), pick_size(4097, 8191, 10),
                      $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 3));
      if (ph == 5) begin
        // Hold off the sender until every result is back.
        push_random(PHASE_N / 2);
        wait_drained();
        push_random(PHASE_N / 2);
      end else begin
        push_random(PHASE_N);
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("** image_convolution_2d_unit: PASSED **");
    end else begin
      $display("** image_convolution_2d_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
